/* hdl/b64e_pkg.sv */
// b64e_pkg: shared types, character codes and the sextet-to-ASCII function
// for the line-wrapped base64 encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned QUAD_CNT_W = 5;
    localparam int unsigned WORD_W     = 24;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    // Character slots within one job; quads start at SLOT_S0, bare CR LF at SLOT_CR.
    localparam logic [2:0] SLOT_S0 = 3'd0;
    localparam logic [2:0] SLOT_S1 = 3'd1;
    localparam logic [2:0] SLOT_S2 = 3'd2;
    localparam logic [2:0] SLOT_S3 = 3'd3;
    localparam logic [2:0] SLOT_CR = 3'd4;
    localparam logic [2:0] SLOT_LF = 3'd5;

    // One queued unit of output work: an optional quad and an optional CR LF.
    typedef struct packed {
        logic                has_quad;
        logic                add_crlf;
        logic [1:0]          pad_count;
        logic [WORD_W-1:0]   word;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'd0;
        if (v inside {[6'd0:6'd25]})
            c = 8'd65 + {2'b00, v};
        else if (v inside {[6'd26:6'd51]})
            c = 8'd71 + {2'b00, v};
        else if (v inside {[6'd52:6'd61]})
            c = {2'b00, v} - 8'd4;
        else if (v == 6'd62)
            c = 8'd43;
        else
            c = 8'd47;
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/b64e_front.sv */
// b64e_front: accepts message bytes, gathers triplets, tracks line position
// and pushes one job per item that gives output. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front #(
    parameter int unsigned QUADS_PER_LINE = 19
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        carries_byte,
    input  wire logic                        ends_message,
    input  wire logic                        queue_full,
    output logic                             push,
    output b64e_pkg::job_t                   push_job
);

    logic [15:0]                         held_reg, held_next;
    logic [1:0]                          count_reg, count_next;
    logic [b64e_pkg::QUAD_CNT_W-1:0]     quads_reg, quads_next;
    logic                                started_reg, started_next;

    logic                                accept;
    logic [15:0]                         c_held;
    logic [1:0]                          c_count;
    logic [b64e_pkg::QUAD_CNT_W-1:0]     c_quads;
    logic [b64e_pkg::QUAD_CNT_W-1:0]     quads_inc;
    logic                                c_started;
    logic                                quad_full;
    logic                                wrap;
    b64e_pkg::job_t                      job;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign quads_inc = quads_reg + 1'b1;

    always_comb
    begin
        // effect of the carried byte
        c_held    = held_reg;
        c_count   = count_reg;
        c_quads   = quads_reg;
        c_started = started_reg;
        quad_full = 1'b0;
        wrap      = 1'b0;
        if (carries_byte)
        begin
            c_started = 1'b1;
            if (count_reg == 2'd2)
            begin
                quad_full = 1'b1;
                c_held    = 16'd0;
                c_count   = 2'd0;
                if (quads_inc >= b64e_pkg::QUAD_CNT_W'(QUADS_PER_LINE))
                begin
                    wrap    = 1'b1;
                    c_quads = '0;
                end
                else
                begin
                    c_quads = quads_inc;
                end
            end
            else
            begin
                c_held  = {held_reg[7:0], data_byte};
                c_count = count_reg + 2'd1;
            end
        end

        // classify into a job
        job.has_quad  = quad_full;
        job.add_crlf  = wrap;
        job.pad_count = 2'd0;
        job.word      = {held_reg, data_byte};
        if (ends_message)
        begin
            if (c_count == 2'd1)
            begin
                job.has_quad  = 1'b1;
                job.add_crlf  = 1'b1;
                job.pad_count = 2'd2;
                job.word      = {c_held[7:0], 16'd0};
            end
            else if (c_count == 2'd2)
            begin
                job.has_quad  = 1'b1;
                job.add_crlf  = 1'b1;
                job.pad_count = 2'd1;
                job.word      = {c_held, 8'd0};
            end
            else
            begin
                job.add_crlf = wrap || (c_quads != '0) || !c_started;
            end
        end

        held_next    = held_reg;
        count_next   = count_reg;
        quads_next   = quads_reg;
        started_next = started_reg;
        if (accept)
        begin
            if (ends_message)
            begin
                held_next    = 16'd0;
                count_next   = 2'd0;
                quads_next   = '0;
                started_next = 1'b0;
            end
            else
            begin
                held_next    = c_held;
                count_next   = c_count;
                quads_next   = c_quads;
                started_next = c_started;
            end
        end
    end

    assign push     = accept && (job.has_quad || job.add_crlf);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 16'd0;
            count_reg   <= 2'd0;
            quads_reg   <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            held_reg    <= held_next;
            count_reg   <= count_next;
            quads_reg   <= quads_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/b64e_queue.sv */
// b64e_queue: small register FIFO that decouples the front from the back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
    parameter int unsigned WIDTH = 28,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (do_push)
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/b64e_back.sv */
// b64e_back: pulls jobs from the queue and writes them out one character per
// cycle while out_stall is low, through an output register. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            queue_empty,
    input  wire b64e_pkg::job_t  queue_job,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           out_char,
    output logic                 last_of_run
);

    b64e_pkg::job_t job_reg;
    logic           busy_reg, busy_next;
    logic [2:0]     slot_reg, slot_next;
    logic           valid_reg, valid_next;
    logic [7:0]     char_reg;
    logic           last_reg;

    logic           advance;
    logic           is_last;
    logic [7:0]     cur_char;

    assign advance = busy_reg && (!valid_reg || !out_stall);
    assign is_last = (slot_reg == b64e_pkg::SLOT_LF)
                  || ((slot_reg == b64e_pkg::SLOT_S3) && !job_reg.add_crlf);
    assign pop     = !queue_empty && (!busy_reg || (advance && is_last));

    always_comb
    begin
        case (slot_reg)
            b64e_pkg::SLOT_S0: cur_char = b64e_pkg::sextet_char(job_reg.word[23:18]);
            b64e_pkg::SLOT_S1: cur_char = b64e_pkg::sextet_char(job_reg.word[17:12]);
            b64e_pkg::SLOT_S2: cur_char = (job_reg.pad_count == 2'd2) ? b64e_pkg::CHAR_PAD
                                        : b64e_pkg::sextet_char(job_reg.word[11:6]);
            b64e_pkg::SLOT_S3: cur_char = (job_reg.pad_count != 2'd0) ? b64e_pkg::CHAR_PAD
                                        : b64e_pkg::sextet_char(job_reg.word[5:0]);
            b64e_pkg::SLOT_CR: cur_char = b64e_pkg::CHAR_CR;
            b64e_pkg::SLOT_LF: cur_char = b64e_pkg::CHAR_LF;
            default:           cur_char = b64e_pkg::CHAR_LF;
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            slot_next  = slot_reg + 3'd1;
            if (is_last)
                busy_next = 1'b0;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            busy_next = 1'b1;
            slot_next = queue_job.has_quad ? b64e_pkg::SLOT_S0 : b64e_pkg::SLOT_CR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= queue_job;
        if (advance)
        begin
            char_reg <= cur_char;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            slot_reg  <= b64e_pkg::SLOT_S0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

/* hdl/base64_line_wrapped_encoder_top.sv */
// Streaming MIME base64 encoder with CR LF line wrapping: the top level.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// The encoder takes one message byte per input word and gives base64 characters
// one per output word. Three bytes make four characters; after QUADS_PER_LINE
// quads (76 characters by default) a CR LF follows. A word with ends_message set
// closes the message: a partial triplet is padded with '=' and CR LF closes the
// output, except when a line has just been closed. last_of_run marks the final
// character caused by an input word; a word may cause no characters at all.
// Input words are taken every cycle while the job queue (QUEUE_DEPTH entries)
// has room. The output side gives one character per cycle while out_stall is
// low, so a word costs as much output time as the characters it causes (0 to 6);
// the output register is the pace-setting unit. An accepted word reaches the
// output through the queue, the back's job register and the output register.
`timescale 1ns / 1ps
`default_nettype none

module base64_line_wrapped_encoder_top #(
    parameter int unsigned QUADS_PER_LINE = 19,
    parameter int unsigned QUEUE_DEPTH    = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       carries_byte,
    input  wire logic       ends_message,
    // output channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_char,
    output logic            last_of_run
);

    localparam int unsigned JOB_W = $bits(b64e_pkg::job_t);

    logic             push;
    b64e_pkg::job_t   push_job;
    logic             pop;
    logic [JOB_W-1:0] pop_bits;
    b64e_pkg::job_t   pop_job;
    logic             queue_full;
    logic             queue_empty;

    // Front: hold partial triplets and line position, classify each word.
    b64e_front #(
        .QUADS_PER_LINE (QUADS_PER_LINE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .carries_byte (carries_byte),
        .ends_message (ends_message),
        .queue_full   (queue_full),
        .push         (push),
        .push_job     (push_job)
    );

    // Queue: let the front run ahead while the back drains characters.
    b64e_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_bits),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    assign pop_job = b64e_pkg::job_t'(pop_bits);

    // Back: expand each job to characters, advance one per cycle unless stalled.
    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_job   (pop_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

/* hdl/b64e_checker.sv */
// b64e_checker: port-level assertions for the base64 encoder, bound to the
// top level. Depends on b64e_pkg and base64_line_wrapped_encoder_top ports.
`timescale 1ns / 1ps
`default_nettype none

module b64e_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_char,
    input wire logic       last_of_run
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
        else $error("output word changed while stalled");

    // CR is always followed by LF within the same run.
    a_cr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == b64e_pkg::CHAR_CR) |-> !last_of_run)
        else $error("CR closed a run");

    // Every LF closes its run.
    a_lf_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == b64e_pkg::CHAR_LF) |-> last_of_run)
        else $error("LF inside a run");

    // Padding is always followed by CR LF.
    a_pad_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == b64e_pkg::CHAR_PAD) |-> !last_of_run)
        else $error("padding closed a run");

endmodule

bind base64_line_wrapped_encoder_top b64e_checker u_b64e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
);

`default_nettype wire
